### hdl/vsr_pkg.sv
// ----------------------------------------------------------------------------
// vsr_pkg - shared types and constants of the vcpu snake rebalancer
// Transfer structs, sequencer states, register indexes and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package vsr_pkg;

  // default capacities
  localparam int MAX_PCPUS_DEF   = 8;
  localparam int MAX_DOMAINS_DEF = 16;

  // field widths
  localparam int TIME_W  = 63;
  localparam int USAGE_W = 7;
  localparam int SUM_W   = 12;   // sum of up to 32 usages
  localparam int SQS_W   = 19;   // sum of up to 32 squared usages
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 32;
  localparam int ALU_W   = 65;

  localparam logic [USAGE_W-1:0] USAGE_FULL = 7'd100;
  localparam logic [6:0]         PCT_SCALE  = 7'd100;

  // reset values of the registers
  localparam logic [5:0] PCPU_COUNT_RST   = 6'd4;
  localparam logic [6:0] DOMAIN_COUNT_RST = 7'd4;
  localparam logic [6:0] THRESHOLD_RST    = 7'd5;

  // register indexes
  localparam logic [1:0] REG_PCPU_COUNT   = 2'd0;
  localparam logic [1:0] REG_DOMAIN_COUNT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  // sample modes
  localparam logic [1:0] MODE_CPU = 2'd0;
  localparam logic [1:0] MODE_DOM = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [5:0]        item_index;
    logic [TIME_W-1:0] busy_us;
    logic [TIME_W-1:0] idle_us;
    logic [TIME_W-1:0] run_us;
  } in_t;

  typedef struct packed {
    logic       rebalanced;
    logic [5:0] domain_index;
    logic [4:0] target_pcpu;
    logic       last;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CPU_DB,
    ST_CPU_DI,
    ST_CPU_SUM,
    ST_DIV_A,
    ST_DIV_B1,
    ST_DIV_B2,
    ST_DIV_DONE,
    ST_DOM,
    ST_EMIT_SKIP,
    ST_SP_ACC,
    ST_SP_M1,
    ST_SP_M2,
    ST_SP_M3,
    ST_SP_M4,
    ST_SP_M5,
    ST_SP_CMP,
    ST_FIRST_MOD,
    ST_SORT_INIT,
    ST_PASS_START,
    ST_SCAN,
    ST_SWAP1,
    ST_SWAP2,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### hdl/vcpu_snake_rebalancer.sv
// CPU sample: one shared 65-bit adder, one or three steps per quotient bit of
//   the 7-bit percentage; domain sample: one subtraction on the same adder.
// Interval end: a single result when skipped, else the spread test, the start
//   CPU fold and the selection sort, then one result per cycle unless the
//   output stalls, all through the same adder and one multiplier.
// Throughput: one item at a time; in_ready is high only between items.
// Reset (synchronous): registers to defaults, history and deltas to zero,
//   domain order to identity, start CPU 0, next interval skipped.
// ----------------------------------------------------------------------------
// vcpu_snake_rebalancer - top level
// Usage tracking, spread test, selection sort and snake pin assignment.
// ----------------------------------------------------------------------------
`default_nettype none

module vcpu_snake_rebalancer
  import vsr_pkg::*;
#(
  parameter int MAX_PCPUS   = MAX_PCPUS_DEF,
  parameter int MAX_DOMAINS = MAX_DOMAINS_DEF
) (
  input  wire  logic       clk,
  input  wire  logic       rst,
  input  wire  logic       cfg_we,
  input  wire  logic [1:0] cfg_index,
  input  wire  logic [6:0] cfg_data,
  input  wire  logic       in_valid,
  output logic             in_ready,
  input  wire  in_t        in_data,
  output logic             out_valid,
  input  wire  logic       out_ready,
  output out_t             out_data
);

  localparam int PIDX_W = (MAX_PCPUS > 1) ? $clog2(MAX_PCPUS) : 1;
  localparam int PCNT_W = $clog2(MAX_PCPUS + 1);
  localparam int DIDX_W = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
  localparam int DCNT_W = $clog2(MAX_DOMAINS + 1);

  // configuration
  logic [5:0] pcpu_count;
  logic [6:0] domain_count;
  logic [6:0] spread_threshold;

  // per-CPU and per-domain state
  logic [TIME_W-1:0]  prev_busy    [MAX_PCPUS];
  logic [TIME_W-1:0]  prev_idle    [MAX_PCPUS];
  logic [USAGE_W-1:0] pcpu_usage   [MAX_PCPUS];
  logic [TIME_W-1:0]  prev_run     [MAX_DOMAINS];
  logic [TIME_W-1:0]  domain_delta [MAX_DOMAINS];
  logic [DIDX_W-1:0]  domain_order [MAX_DOMAINS];
  logic [PIDX_W-1:0]  first_pcpu;
  logic               skip_next;

  // working registers
  state_t             state, state_next;
  logic [5:0]         op_idx;
  logic [TIME_W-1:0]  op_a, op_b;
  logic [TIME_W-1:0]  db, di;
  logic [63:0]        den;
  logic [ALU_W-1:0]   rem;
  logic [USAGE_W-1:0] quo;
  logic [2:0]         bit_cnt;
  logic [PIDX_W-1:0]  cnt;
  logic [SUM_W-1:0]   usum;
  logic [SQS_W-1:0]   qsum;
  logic [PROD_W-1:0]  nq, ss, tt;
  logic [DIDX_W-1:0]  si, sj, sm, k;
  logic [TIME_W-1:0]  max_val, cur_val;
  logic [DIDX_W-1:0]  max_ord, cur_ord;
  logic [PIDX_W-1:0]  jj;
  logic               rev;

  // derived control
  logic [PCNT_W-1:0]  n_eff;
  logic [DCNT_W-1:0]  d_eff;
  logic [PIDX_W-1:0]  pidx;
  logic [DIDX_W-1:0]  didx;
  logic               in_xfer, out_free, out_load;
  logic               idx_ok_cpu, idx_ok_dom;

  // shared adder and multiplier
  logic [ALU_W-1:0]   alu_a, alu_b;
  logic               alu_sub;
  logic [ALU_W:0]     alu_res;
  logic               alu_carry;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [2*MUL_W-1:0] mul_full;

  logic [DIDX_W-1:0]  ord_raddr;
  logic [DIDX_W-1:0]  ord_rdata;
  logic [TIME_W-1:0]  scan_val;
  logic [PCNT_W:0]    cpu_sum;
  logic [PCNT_W:0]    cpu_sel;
  logic               last_k;
  logic [USAGE_W-1:0] u_cur;
  logic [13:0]        u_sq;

  assign pidx       = op_idx[PIDX_W-1:0];
  assign didx       = op_idx[DIDX_W-1:0];
  assign in_ready   = (state == ST_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign idx_ok_cpu = {1'b0, in_data.item_index} < 7'(MAX_PCPUS);
  assign idx_ok_dom = {1'b0, in_data.item_index} < 7'(MAX_DOMAINS);

  // clamp the counts to the supported range
  always_comb begin
    if (pcpu_count == 6'd0) begin
      n_eff = PCNT_W'(1);
    end else if ({1'b0, pcpu_count} > 7'(MAX_PCPUS)) begin
      n_eff = PCNT_W'(MAX_PCPUS);
    end else begin
      n_eff = PCNT_W'(pcpu_count);
    end
    if (domain_count == 7'd0) begin
      d_eff = DCNT_W'(1);
    end else if ({1'b0, domain_count} > 8'(MAX_DOMAINS)) begin
      d_eff = DCNT_W'(MAX_DOMAINS);
    end else begin
      d_eff = DCNT_W'(domain_count);
    end
  end

  // adder operand selection
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state)
      ST_CPU_DB: begin
        alu_a = ALU_W'(op_a);
        alu_b = ALU_W'(prev_busy[pidx]);
      end
      ST_CPU_DI: begin
        alu_a = ALU_W'(op_b);
        alu_b = ALU_W'(prev_idle[pidx]);
      end
      ST_CPU_SUM: begin
        alu_a   = ALU_W'(db);
        alu_b   = ALU_W'(di);
        alu_sub = 1'b0;
      end
      ST_DIV_A: begin
        alu_a = {rem[63:0], 1'b0};
        alu_b = ALU_W'(den);
      end
      ST_DIV_B1: begin
        alu_a   = rem;
        alu_b   = ALU_W'(db);
        alu_sub = 1'b0;
      end
      ST_DIV_B2: begin
        alu_a = rem;
        alu_b = ALU_W'(den);
      end
      ST_DOM: begin
        alu_a = ALU_W'(op_a);
        alu_b = ALU_W'(prev_run[didx]);
      end
      ST_SCAN: begin
        alu_a = ALU_W'(max_val);
        alu_b = ALU_W'(scan_val);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W + 1)'(alu_sub);
  assign alu_carry = alu_res[ALU_W];

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SP_M1: begin
        mul_a = MUL_W'(n_eff);
        mul_b = MUL_W'(qsum);
      end
      ST_SP_M2: begin
        mul_a = MUL_W'(usum);
        mul_b = MUL_W'(usum);
      end
      ST_SP_M3: begin
        mul_a = MUL_W'(spread_threshold);
        mul_b = MUL_W'(spread_threshold);
      end
      ST_SP_M4, ST_SP_M5: begin
        mul_a = tt[MUL_W-1:0];
        mul_b = MUL_W'(n_eff);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[PROD_W-1:0];

  // order read port
  always_comb begin
    unique case (state)
      ST_SCAN:  ord_raddr = sj;
      ST_EMIT:  ord_raddr = k;
      default:  ord_raddr = si;
    endcase
  end
  assign ord_rdata = domain_order[ord_raddr];
  assign scan_val  = domain_delta[sj];

  // usage square for the spread sums
  assign u_cur = pcpu_usage[cnt];
  assign u_sq  = u_cur * u_cur;

  // snake target cpu
  assign cpu_sum = (PCNT_W + 1)'(jj) + (PCNT_W + 1)'(first_pcpu);
  assign cpu_sel = (cpu_sum >= (PCNT_W + 1)'(n_eff)) ?
                   cpu_sum - (PCNT_W + 1)'(n_eff) : cpu_sum;
  assign last_k  = (DCNT_W'(k) + DCNT_W'(1)) == d_eff;

  // next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          priority case (in_data.mode)
            MODE_CPU: state_next = idx_ok_cpu ? ST_CPU_DB : ST_IDLE;
            MODE_DOM: state_next = idx_ok_dom ? ST_DOM : ST_IDLE;
            MODE_END: state_next = skip_next ? ST_EMIT_SKIP : ST_SP_ACC;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CPU_DB: begin
        state_next = (prev_busy[pidx] == '0) ? ST_IDLE : ST_CPU_DI;
      end
      ST_CPU_DI: state_next = ST_CPU_SUM;
      ST_CPU_SUM: begin
        if (alu_res[63:0] == 64'd0 || di == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (PCT_SCALE[bit_cnt]) begin
          state_next = ST_DIV_B1;
        end else if (bit_cnt == 3'd0) begin
          state_next = ST_DIV_DONE;
        end
      end
      ST_DIV_B1: state_next = ST_DIV_B2;
      ST_DIV_B2: state_next = (bit_cnt == 3'd0) ? ST_DIV_DONE : ST_DIV_A;
      ST_DIV_DONE: state_next = ST_IDLE;
      ST_DOM: state_next = ST_IDLE;
      ST_EMIT_SKIP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SP_ACC: begin
        if ((PCNT_W'(cnt) + PCNT_W'(1)) == n_eff) begin
          state_next = ST_SP_M1;
        end
      end
      ST_SP_M1: state_next = ST_SP_M2;
      ST_SP_M2: state_next = ST_SP_M3;
      ST_SP_M3: state_next = ST_SP_M4;
      ST_SP_M4: state_next = ST_SP_M5;
      ST_SP_M5: state_next = ST_SP_CMP;
      ST_SP_CMP: begin
        state_next = (nq <= ss + tt) ? ST_EMIT_SKIP : ST_FIRST_MOD;
      end
      ST_FIRST_MOD: begin
        if (PCNT_W'(first_pcpu) < n_eff) begin
          state_next = ST_SORT_INIT;
        end
      end
      ST_SORT_INIT: begin
        state_next = (d_eff == DCNT_W'(1)) ? ST_EMIT : ST_PASS_START;
      end
      ST_PASS_START: state_next = ST_SCAN;
      ST_SCAN: begin
        if ((DCNT_W'(sj) + DCNT_W'(1)) == d_eff) begin
          state_next = ST_SWAP1;
        end
      end
      ST_SWAP1: state_next = ST_SWAP2;
      ST_SWAP2: begin
        if ((DCNT_W'(si) + DCNT_W'(2)) >= d_eff) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PASS_START;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_k) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pcpu_count       <= PCPU_COUNT_RST;
      domain_count     <= DOMAIN_COUNT_RST;
      spread_threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_PCPU_COUNT:   pcpu_count       <= cfg_data[5:0];
        REG_DOMAIN_COUNT: domain_count     <= cfg_data;
        REG_THRESHOLD:    spread_threshold <= cfg_data;
        default:          pcpu_count       <= pcpu_count;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_EMIT) begin
        out_data.rebalanced   <= 1'b1;
        out_data.domain_index <= 6'(ord_rdata);
        out_data.target_pcpu  <= 5'(cpu_sel);
        out_data.last         <= last_k;
      end else begin
        out_data.rebalanced   <= 1'b0;
        out_data.domain_index <= 6'd0;
        out_data.target_pcpu  <= 5'd0;
        out_data.last         <= 1'b1;
      end
    end
  end

  // history, usage, deltas, order and interval flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PCPUS; i++) begin
        prev_busy[i]  <= '0;
        prev_idle[i]  <= '0;
        pcpu_usage[i] <= '0;
      end
      for (int i = 0; i < MAX_DOMAINS; i++) begin
        prev_run[i]     <= '0;
        domain_delta[i] <= '0;
        domain_order[i] <= DIDX_W'(i);
      end
      first_pcpu <= '0;
      skip_next  <= 1'b1;
    end else begin
      unique case (state)
        ST_CPU_DB: begin
          if (prev_busy[pidx] == '0) begin
            prev_busy[pidx] <= op_a;
            prev_idle[pidx] <= op_b;
          end
        end
        ST_CPU_DI: begin
          prev_busy[pidx] <= op_a;
          prev_idle[pidx] <= op_b;
        end
        ST_CPU_SUM: begin
          if (alu_res[63:0] != 64'd0 && di == '0) begin
            pcpu_usage[pidx] <= USAGE_FULL;
          end
        end
        ST_DIV_DONE: pcpu_usage[pidx] <= quo;
        ST_DOM: begin
          if (prev_run[didx] != '0) begin
            domain_delta[didx] <= alu_res[TIME_W-1:0];
          end
          prev_run[didx] <= op_a;
        end
        ST_EMIT_SKIP: begin
          if (out_free) begin
            skip_next <= 1'b0;
          end
        end
        ST_FIRST_MOD: begin
          if (PCNT_W'(first_pcpu) >= n_eff) begin
            first_pcpu <= PIDX_W'(PCNT_W'(first_pcpu) - n_eff);
          end
        end
        ST_SORT_INIT: begin
          for (int i = 0; i < MAX_DOMAINS; i++) begin
            domain_order[i] <= DIDX_W'(i);
          end
        end
        ST_SWAP1: begin
          domain_delta[sm] <= cur_val;
          domain_order[sm] <= cur_ord;
        end
        ST_SWAP2: begin
          domain_delta[si] <= max_val;
          domain_order[si] <= max_ord;
        end
        ST_EMIT: begin
          if (out_free && last_k) begin
            skip_next <= 1'b1;
            if ((PCNT_W'(first_pcpu) + PCNT_W'(1)) == n_eff) begin
              first_pcpu <= '0;
            end else begin
              first_pcpu <= first_pcpu + PIDX_W'(1);
            end
          end
        end
        default: begin
          skip_next <= skip_next;
        end
      endcase
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          op_idx <= in_data.item_index;
          op_a   <= (in_data.mode == MODE_DOM) ? in_data.run_us : in_data.busy_us;
          op_b   <= in_data.idle_us;
        end
        cnt  <= '0;
        usum <= '0;
        qsum <= '0;
      end
      ST_CPU_DB: db <= alu_res[TIME_W-1:0];
      ST_CPU_DI: di <= alu_res[TIME_W-1:0];
      ST_CPU_SUM: begin
        den     <= alu_res[63:0];
        rem     <= '0;
        quo     <= '0;
        bit_cnt <= 3'd6;
      end
      ST_DIV_A: begin
        // remainder doubles, subtract the divisor when it fits
        if (alu_carry) begin
          rem <= ALU_W'(alu_res[63:0]);
        end else begin
          rem <= {rem[63:0], 1'b0};
        end
        quo <= {quo[USAGE_W-2:0], alu_carry};
        if (!PCT_SCALE[bit_cnt] && bit_cnt != 3'd0) begin
          bit_cnt <= bit_cnt - 3'd1;
        end
      end
      ST_DIV_B1: rem <= alu_res[ALU_W-1:0];
      ST_DIV_B2: begin
        if (alu_carry) begin
          rem <= alu_res[ALU_W-1:0];
          quo <= quo + USAGE_W'(1);
        end
        if (bit_cnt != 3'd0) begin
          bit_cnt <= bit_cnt - 3'd1;
        end
      end
      ST_SP_ACC: begin
        usum <= usum + SUM_W'(u_cur);
        qsum <= qsum + SQS_W'(u_sq);
        cnt  <= cnt + PIDX_W'(1);
      end
      ST_SP_M1: nq <= mul_p;
      ST_SP_M2: ss <= mul_p;
      ST_SP_M3: tt <= mul_p;
      ST_SP_M4: tt <= mul_p;
      ST_SP_M5: tt <= mul_p;
      ST_SORT_INIT: begin
        si  <= '0;
        k   <= '0;
        jj  <= '0;
        rev <= 1'b0;
      end
      ST_PASS_START: begin
        cur_val <= domain_delta[si];
        max_val <= domain_delta[si];
        cur_ord <= ord_rdata;
        max_ord <= ord_rdata;
        sm      <= si;
        sj      <= si + DIDX_W'(1);
      end
      ST_SCAN: begin
        // strictly larger delta takes over, ties keep the earlier one
        if (!alu_carry) begin
          max_val <= scan_val;
          max_ord <= ord_rdata;
          sm      <= sj;
        end
        if ((DCNT_W'(sj) + DCNT_W'(1)) != d_eff) begin
          sj <= sj + DIDX_W'(1);
        end
      end
      ST_SWAP2: begin
        si  <= si + DIDX_W'(1);
        k   <= '0;
        jj  <= '0;
        rev <= 1'b0;
      end
      ST_EMIT: begin
        if (out_free) begin
          k <= k + DIDX_W'(1);
          // snake: up to n-1, then back down to 0
          if (!rev) begin
            if ((PCNT_W'(jj) + PCNT_W'(1)) == n_eff) begin
              rev <= 1'b1;
            end else begin
              jj <= jj + PIDX_W'(1);
            end
          end else begin
            if (jj == '0) begin
              rev <= 1'b0;
            end else begin
              jj <= jj - PIDX_W'(1);
            end
          end
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // checks
  a_usage_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_DONE) |-> (quo < USAGE_FULL))
    else $error("usage quotient out of range");

  a_skip_set_on_last: assert property (@(posedge clk) disable iff (rst)
    $rose(skip_next) |-> ($past(state) == ST_EMIT && $past(last_k)))
    else $error("skip flag set outside the last pin result");

  a_first_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (PCNT_W'(first_pcpu) < n_eff))
    else $error("start cpu not folded below cpu count");

  a_cpu_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (cpu_sel < (PCNT_W + 1)'(n_eff)))
    else $error("target cpu out of range");

endmodule

`default_nettype wire
